// ----- src/tnet_pkg.sv -----
// Shared constants and types for the timed note event trigger.
// No dependencies.
package tnet_pkg;

  localparam int MAX_EVENTS_DEF   = 64;
  localparam int NUM_VOICES_DEF   = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 16;
  localparam int PAY_W   = 32;
  localparam int VOICE_W = 8;
  localparam int MASK_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_SEEK  = 3'd3,
    CMD_PLAY  = 3'd4,
    CMD_PAUSE = 3'd5,
    CMD_STOP  = 3'd6
  } cmd_t;

endpackage

// ----- src/tnet_if.sv -----
// Valid/ready channel interfaces for command items and played-note items.
// Depends on tnet_pkg.
interface tnet_cmd_if import tnet_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [TIME_W-1:0]         time_value;
  logic [DELTA_W-1:0]        delta_ms;
  logic [PAY_W-1:0]          note_payload;
  logic signed [VOICE_W-1:0] note_voice;
  logic                      filter_enable;
  logic [MASK_W-1:0]         solo_mask;
  logic [MASK_W-1:0]         mute_mask;

  modport source (output valid, command, time_value, delta_ms, note_payload, note_voice,
                  filter_enable, solo_mask, mute_mask, input ready);
  modport sink (input valid, command, time_value, delta_ms, note_payload, note_voice,
                filter_enable, solo_mask, mute_mask, output ready);
endinterface

interface tnet_play_if import tnet_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PAY_W-1:0]          play_payload;
  logic signed [VOICE_W-1:0] play_voice;
  logic                      last;

  modport source (output valid, play_payload, play_voice, last, input ready);
  modport sink (input valid, play_payload, play_voice, last, output ready);
endinterface

// ----- src/tnet_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tnet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/timed_note_event_trigger.sv -----
// Timed note event trigger: note table in RAM, playhead, sequential tick walk.
// Depends on tnet_pkg, tnet_if, tnet_ram.
//
// Commands that walk the note table step one entry per cycle through the RAM
// read port, unless a tick stalls on the play channel: a tick while running
// walks every stored note, then flushes any held result; set playhead and stop
// walk it to set or clear the triggered flags. Other commands never leave idle.
// A tick that fires the last untriggered note also returns to stopped and
// walks the table again, clearing the triggered flags. An empty table never
// walks. The play channel has an output register, so results may wait while
// the next command is accepted. No clearing pass follows reset.
module timed_note_event_trigger import tnet_pkg::*; #(
  parameter int MAX_EVENTS   = MAX_EVENTS_DEF,
  parameter int NUM_VOICES   = NUM_VOICES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tnet_cmd_if.sink      cmd,
  tnet_play_if.source   play
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_EVENTS + 1);
  localparam int PW = PAYLOAD_BITS;
  localparam int DW = TIME_W + PW + VOICE_W;
  localparam logic [31:0] VOICE_MASK = 32'((64'd1 << NUM_VOICES) - 64'd1);

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_FLUSH, S_MARK, S_CLR} state_t;

  state_t              state;
  logic [AW-1:0]       idx;
  logic [CW-1:0]       count;
  logic [TIME_W-1:0]   playhead;
  logic                running;
  logic                pending;
  logic                f_en;
  logic                any_solo;
  logic [MASK_W-1:0]   solo;
  logic [MASK_W-1:0]   mute;
  logic                hold_valid;
  logic [PAY_W-1:0]    hold_pay;
  logic [VOICE_W-1:0]  hold_voice;
  logic                out_valid;
  logic [PAY_W-1:0]    out_pay;
  logic [VOICE_W-1:0]  out_voice;
  logic                out_last;

  logic                accept;
  logic                stall;
  logic                out_free;
  logic                out_load;
  logic                last_step;
  logic [AW-1:0]       rd_addr;
  logic                d_we;
  logic [DW-1:0]       d_wdata;
  logic [DW-1:0]       d_rdata;
  logic                f_we;
  logic [AW-1:0]       f_waddr;
  logic                f_wdata;
  logic                f_rdata;
  logic [63:0]         pay_in64;
  logic [63:0]         pay_rd64;
  logic [TIME_W-1:0]   e_time;
  logic [PAY_W-1:0]    e_pay;
  logic [VOICE_W-1:0]  e_voice;
  logic                hit;
  logic                pass;
  logic                emit;
  logic                in_range;
  logic [31:0]         solo32;
  logic [31:0]         mute32;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign out_free  = !out_valid || play.ready;

  assign play.valid        = out_valid;
  assign play.play_payload = out_pay;
  assign play.play_voice   = out_voice;
  assign play.last         = out_last;

  // Table entry fields
  assign pay_in64 = 64'(cmd.note_payload);
  assign d_wdata  = {cmd.note_voice, pay_in64[PW-1:0], cmd.time_value};
  assign d_we     = accept && (cmd_t'(cmd.command) == CMD_ADD) && (count < CW'(MAX_EVENTS));
  assign e_time   = d_rdata[TIME_W-1:0];
  assign pay_rd64 = 64'(d_rdata[TIME_W+PW-1:TIME_W]);
  assign e_pay    = pay_rd64[PAY_W-1:0];
  assign e_voice  = d_rdata[DW-1:TIME_W+PW];

  // Solo/mute filter
  assign solo32   = 32'(solo);
  assign mute32   = 32'(mute);
  assign in_range = !e_voice[VOICE_W-1] && (32'(e_voice[VOICE_W-2:0]) < NUM_VOICES);
  assign pass     = !f_en || !in_range ||
                    (any_solo ? solo32[e_voice[4:0]] : !mute32[e_voice[4:0]]);
  assign hit      = !f_rdata && (playhead >= e_time);
  assign emit     = hit && pass;

  assign stall     = (state == S_TICK) && emit && hold_valid && !out_free;
  assign last_step = (CW'(idx) == count - CW'(1));

  // held result moves to the output register
  assign out_load = ((state == S_TICK) && !stall && emit && hold_valid) ||
                    ((state == S_FLUSH) && hold_valid && out_free);

  always_comb begin
    rd_addr = '0;
    f_we    = 1'b0;
    f_waddr = idx;
    f_wdata = 1'b0;
    unique case (state)
      S_IDLE: begin
        f_we    = d_we;
        f_waddr = count[AW-1:0];
      end
      S_TICK: begin
        rd_addr = stall ? idx : idx + AW'(1);
        f_we    = hit && !stall;
        f_wdata = 1'b1;
      end
      S_MARK: begin
        rd_addr = idx + AW'(1);
        f_we    = 1'b1;
        f_wdata = (e_time < playhead);
      end
      S_CLR: begin
        f_we = 1'b1;
      end
      S_FLUSH: ;
      default: ;
    endcase
  end

  tnet_ram #(.WIDTH(DW), .DEPTH(MAX_EVENTS)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (count[AW-1:0]),
    .wdata (d_wdata),
    .raddr (rd_addr),
    .rdata (d_rdata)
  );

  tnet_ram #(.WIDTH(1), .DEPTH(MAX_EVENTS)) u_fired_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (rd_addr),
    .rdata (f_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      count      <= '0;
      playhead   <= '0;
      running    <= 1'b0;
      pending    <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_pay   <= hold_pay;
        out_voice <= hold_voice;
        out_last  <= (state == S_FLUSH);
      end else if (play.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd_t'(cmd.command))
              CMD_TICK: begin
                if (running) begin
                  playhead <= playhead + TIME_W'(cmd.delta_ms);
                  f_en     <= cmd.filter_enable;
                  any_solo <= cmd.filter_enable && ((32'(cmd.solo_mask) & VOICE_MASK) != '0);
                  solo     <= cmd.solo_mask;
                  mute     <= cmd.mute_mask;
                  pending  <= 1'b0;
                  idx      <= '0;
                  if (count != '0) begin
                    state <= S_TICK;
                  end
                end
              end
              CMD_ADD: begin
                if (d_we) begin
                  count <= count + CW'(1);
                end
              end
              CMD_CLEAR: count <= '0;
              CMD_SEEK: begin
                playhead <= cmd.time_value;
                idx      <= '0;
                if (count != '0) begin
                  state <= S_MARK;
                end
              end
              CMD_PLAY:  running <= 1'b1;
              CMD_PAUSE: running <= 1'b0;
              CMD_STOP: begin
                running  <= 1'b0;
                playhead <= '0;
                idx      <= '0;
                if (count != '0) begin
                  state <= S_CLR;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (!stall) begin
            if (emit) begin
              hold_valid <= 1'b1;
              hold_pay   <= e_pay;
              hold_voice <= e_voice;
            end
            if (!f_rdata && !hit) begin
              pending <= 1'b1;
            end
            if (last_step) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (hold_valid) begin
            if (out_free) begin
              hold_valid <= 1'b0;
            end
          end else if (!pending) begin
            running  <= 1'b0;
            playhead <= '0;
            idx      <= '0;
            state    <= S_CLR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MARK, S_CLR: begin
          if (last_step) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
